// ===== hw/rtl/lc2k_pkg.sv =====
// ----------------------------------------------------------------------------
// LC-2K executor package
// Shared constants, codes and the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package lc2k_pkg;

  // Word memory depth. The address arithmetic wraps by truncation, so the
  // depth must stay a power of two.
  localparam int unsigned MEM_WORDS = 65536;
  localparam int unsigned MEM_AW    = $clog2(MEM_WORDS);
  localparam int unsigned NUM_REGS  = 8;
  localparam int unsigned REG_AW    = $clog2(NUM_REGS);
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned ADDR_W    = 16;
  localparam int unsigned IR_W      = 25;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_STEP  = 2'd1,
    CMD_RDREG = 2'd2,
    CMD_RDMEM = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_NOR  = 3'd1,
    OP_LW   = 3'd2,
    OP_SW   = 3'd3,
    OP_BEQ  = 3'd4,
    OP_JALR = 3'd5,
    OP_HALT = 3'd6,
    OP_NOOP = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    ST_RUN   = 2'd0,
    ST_HALT  = 2'd1,
    ST_ERROR = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ADDR_IN,
    ADDR_PC,
    ADDR_EA
  } addr_sel_e;

  typedef enum logic [2:0] {
    RES_DATA,
    RES_REG,
    RES_MEM,
    RES_EXEC,
    RES_ZERO
  } res_sel_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_RDREG,
    S_CAPREG,
    S_RDMEM,
    S_CAPMEM,
    S_FETCH,
    S_DECODE,
    S_EXEC,
    S_WB,
    S_RESP
  } state_e;

  typedef struct packed {
    logic      latch_in;
    logic      mem_re;
    logic      mem_we;
    addr_sel_e addr_sel;
    logic      rf_re;
    logic      rf_a_from_ir;
    logic      ir_load;
    logic      exec;
    logic      wb;
    logic      set_error;
    logic      res_load;
    res_sel_e  res_sel;
    logic      out_load;
  } dp_ctl_t;

  typedef struct packed {
    logic stopped;
    logic bad_op;
    logic is_lw;
    logic is_sw;
  } dp_stat_t;

endpackage

// ===== hw/rtl/lc2k_ctrl.sv =====
// ----------------------------------------------------------------------------
// LC-2K controller
// Sequences each command through its states, a step through fetch, decode,
// execute and, for lw, writeback, and owns both handshakes.
// ----------------------------------------------------------------------------
module lc2k_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        command_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  lc2k_pkg::dp_stat_t stat_i,
  output lc2k_pkg::dp_ctl_t  ctl_o
);
  import lc2k_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free   = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    ctl_o      = '{
      latch_in:     1'b0,
      mem_re:       1'b0,
      mem_we:       1'b0,
      addr_sel:     ADDR_IN,
      rf_re:        1'b0,
      rf_a_from_ir: 1'b0,
      ir_load:      1'b0,
      exec:         1'b0,
      wb:           1'b0,
      set_error:    1'b0,
      res_load:     1'b0,
      res_sel:      RES_ZERO,
      out_load:     1'b0
    };

    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          ctl_o.latch_in = 1'b1;
          unique case (cmd_e'(command_i))
            CMD_LOAD:  state_d = S_LOAD;
            CMD_STEP:  state_d = S_FETCH;
            CMD_RDREG: state_d = S_RDREG;
            CMD_RDMEM: state_d = S_RDMEM;
          endcase
        end
      end
      S_LOAD: begin
        ctl_o.mem_we   = 1'b1;
        ctl_o.addr_sel = ADDR_IN;
        ctl_o.res_load = 1'b1;
        ctl_o.res_sel  = RES_DATA;
        state_d        = S_RESP;
      end
      S_RDREG: begin
        ctl_o.rf_re = 1'b1;
        state_d     = S_CAPREG;
      end
      S_CAPREG: begin
        ctl_o.res_load = 1'b1;
        ctl_o.res_sel  = RES_REG;
        state_d        = S_RESP;
      end
      S_RDMEM: begin
        ctl_o.mem_re   = 1'b1;
        ctl_o.addr_sel = ADDR_IN;
        state_d        = S_CAPMEM;
      end
      S_CAPMEM: begin
        ctl_o.res_load = 1'b1;
        ctl_o.res_sel  = RES_MEM;
        state_d        = S_RESP;
      end
      S_FETCH: begin
        if (stat_i.stopped) begin
          ctl_o.res_load = 1'b1;
          ctl_o.res_sel  = RES_ZERO;
          state_d        = S_RESP;
        end else begin
          ctl_o.mem_re   = 1'b1;
          ctl_o.addr_sel = ADDR_PC;
          state_d        = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat_i.bad_op) begin
          ctl_o.set_error = 1'b1;
          ctl_o.res_load  = 1'b1;
          ctl_o.res_sel   = RES_ZERO;
          state_d         = S_RESP;
        end else begin
          ctl_o.ir_load      = 1'b1;
          ctl_o.rf_re        = 1'b1;
          ctl_o.rf_a_from_ir = 1'b1;
          state_d            = S_EXEC;
        end
      end
      S_EXEC: begin
        ctl_o.exec     = 1'b1;
        ctl_o.addr_sel = ADDR_EA;
        ctl_o.mem_we   = stat_i.is_sw;
        if (stat_i.is_lw) begin
          ctl_o.mem_re = 1'b1;
          state_d      = S_WB;
        end else begin
          ctl_o.res_load = 1'b1;
          ctl_o.res_sel  = RES_EXEC;
          state_d        = S_RESP;
        end
      end
      S_WB: begin
        ctl_o.wb       = 1'b1;
        ctl_o.res_load = 1'b1;
        ctl_o.res_sel  = RES_MEM;
        state_d        = S_RESP;
      end
      S_RESP: begin
        if (slot_free) begin
          ctl_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    out_valid_d = ctl_o.out_load || (out_valid_q && out_stall_i);
  end

endmodule

// ===== hw/rtl/lc2k_dp.sv =====
// ----------------------------------------------------------------------------
// LC-2K datapath
// Word memory, register file, PC, instruction count, machine flags and the
// result and output registers.
// ----------------------------------------------------------------------------
module lc2k_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [lc2k_pkg::ADDR_W-1:0]   address_i,
  input  logic [2:0]                    reg_index_i,
  input  logic [lc2k_pkg::WORD_W-1:0]   load_data_i,
  input  lc2k_pkg::dp_ctl_t             ctl_i,
  output lc2k_pkg::dp_stat_t            stat_o,
  output logic [1:0]                    status_o,
  output logic [lc2k_pkg::ADDR_W-1:0]   pc_value_o,
  output logic [lc2k_pkg::WORD_W-1:0]   read_data_o,
  output logic [2:0]                    executed_opcode_o,
  output logic [lc2k_pkg::WORD_W-1:0]   instruction_count_o
);
  import lc2k_pkg::*;

  // Captured command.
  logic [MEM_AW-1:0] addr_q;
  logic [REG_AW-1:0] ri_q;
  logic [WORD_W-1:0] data_q;

  // Word memory, no reset.
  logic [WORD_W-1:0] mem_q [MEM_WORDS];
  logic [WORD_W-1:0] mem_rdata_q;
  logic [MEM_AW-1:0] mem_addr;
  logic [WORD_W-1:0] mem_wdata;

  // Register file with per-entry valid bits standing in for the zero reset.
  logic [WORD_W-1:0]   rf_q [NUM_REGS];
  logic [NUM_REGS-1:0] rf_vld_q;
  logic [WORD_W-1:0]   rdata_a_q, rdata_b_q;
  logic [REG_AW-1:0]   rf_ra, rf_rb, rf_waddr;
  logic                rf_we;
  logic [WORD_W-1:0]   rf_wdata;

  // Machine state.
  logic [MEM_AW-1:0] pc_q, pc_d, pc1;
  logic [WORD_W-1:0] count_q;
  logic              halted_q, error_q;
  logic [IR_W-1:0]   ir_q;
  op_e               op;
  logic [REG_AW-1:0] ir_ra, ir_rb, ir_rd;
  logic [WORD_W-1:0] off_ext, ea_full;
  logic [MEM_AW-1:0] ea;
  logic [WORD_W-1:0] exec_val;

  // Result and output registers.
  logic [WORD_W-1:0] res_q, res_d;
  logic [2:0]        opc_q;
  status_e           out_status_q;
  logic [MEM_AW-1:0] out_pc_q;
  logic [WORD_W-1:0] out_data_q, out_count_q;
  logic [2:0]        out_opc_q;

  assign op      = op_e'(ir_q[24:22]);
  assign ir_ra   = ir_q[21:19];
  assign ir_rb   = ir_q[18:16];
  assign ir_rd   = ir_q[2:0];
  assign off_ext = {{(WORD_W-16){ir_q[15]}}, ir_q[15:0]};
  assign ea_full = off_ext + rdata_a_q;
  assign ea      = ea_full[MEM_AW-1:0];
  assign pc1     = pc_q + MEM_AW'(1);

  assign stat_o.stopped = halted_q || error_q;
  // The opcode is the word shifted right arithmetically by 22; it lies in
  // range only when all bits above the three opcode bits are clear.
  assign stat_o.bad_op  = (mem_rdata_q[WORD_W-1:IR_W] != '0);
  assign stat_o.is_lw   = (op == OP_LW);
  assign stat_o.is_sw   = (op == OP_SW);

  always_ff @(posedge clk_i) begin
    if (ctl_i.latch_in) begin
      addr_q <= address_i[MEM_AW-1:0];
      ri_q   <= reg_index_i;
      data_q <= load_data_i;
    end
  end

  // Memory port.
  always_comb begin
    unique case (ctl_i.addr_sel)
      ADDR_IN: mem_addr = addr_q;
      ADDR_PC: mem_addr = pc_q;
      ADDR_EA: mem_addr = ea;
      default: mem_addr = addr_q;
    endcase
  end

  assign mem_wdata = (ctl_i.addr_sel == ADDR_IN) ? data_q : rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.mem_we) begin
      mem_q[mem_addr] <= mem_wdata;
    end
    if (ctl_i.mem_re) begin
      mem_rdata_q <= mem_q[mem_addr];
    end
  end

  // Register file. In decode the register fields come straight from the
  // fetched word.
  assign rf_ra = ctl_i.rf_a_from_ir ? mem_rdata_q[21:19] : ri_q;
  assign rf_rb = mem_rdata_q[18:16];

  always_comb begin
    unique case (op)
      OP_ADD:  exec_val = rdata_a_q + rdata_b_q;
      OP_NOR:  exec_val = ~(rdata_a_q | rdata_b_q);
      OP_SW:   exec_val = rdata_b_q;
      OP_JALR: exec_val = WORD_W'(pc1);
      default: exec_val = '0;
    endcase
  end

  assign rf_we    = ctl_i.wb ||
                    (ctl_i.exec && (op == OP_ADD || op == OP_NOR || op == OP_JALR));
  assign rf_waddr = (ctl_i.wb || op == OP_JALR) ? ir_rb : ir_rd;
  assign rf_wdata = ctl_i.wb ? mem_rdata_q : exec_val;

  always_ff @(posedge clk_i) begin
    if (rf_we) begin
      rf_q[rf_waddr] <= rf_wdata;
    end
    if (ctl_i.rf_re) begin
      rdata_a_q <= rf_vld_q[rf_ra] ? rf_q[rf_ra] : '0;
      rdata_b_q <= rf_vld_q[rf_rb] ? rf_q[rf_rb] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rf_vld_q <= '0;
    end else if (rf_we) begin
      rf_vld_q[rf_waddr] <= 1'b1;
    end
  end

  // Next PC. A jalr whose two registers match sees the link value.
  always_comb begin
    unique case (op)
      OP_BEQ:  pc_d = (rdata_a_q == rdata_b_q) ? pc1 + ir_q[MEM_AW-1:0] : pc1;
      OP_JALR: pc_d = (ir_ra == ir_rb) ? pc1 : rdata_a_q[MEM_AW-1:0];
      default: pc_d = pc1;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.ir_load) begin
      ir_q <= mem_rdata_q[IR_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q     <= '0;
      count_q  <= '0;
      halted_q <= 1'b0;
      error_q  <= 1'b0;
    end else begin
      if (ctl_i.exec) begin
        pc_q <= pc_d;
        if (count_q != '1) begin
          count_q <= count_q + WORD_W'(1);
        end
        if (op == OP_HALT) begin
          halted_q <= 1'b1;
        end
      end
      if (ctl_i.set_error) begin
        error_q <= 1'b1;
      end
    end
  end

  // Result.
  always_comb begin
    unique case (ctl_i.res_sel)
      RES_DATA: res_d = data_q;
      RES_REG:  res_d = rdata_a_q;
      RES_MEM:  res_d = mem_rdata_q;
      RES_EXEC: res_d = exec_val;
      default:  res_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.res_load) begin
      res_q <= res_d;
    end
    if (ctl_i.latch_in) begin
      opc_q <= '0;
    end else if (ctl_i.exec) begin
      opc_q <= op;
    end
  end

  // Output beat register.
  always_ff @(posedge clk_i) begin
    if (ctl_i.out_load) begin
      out_status_q <= error_q ? ST_ERROR : (halted_q ? ST_HALT : ST_RUN);
      out_pc_q     <= pc_q;
      out_data_q   <= res_q;
      out_opc_q    <= opc_q;
      out_count_q  <= count_q;
    end
  end

  assign status_o            = out_status_q;
  assign pc_value_o          = ADDR_W'(out_pc_q);
  assign read_data_o         = out_data_q;
  assign executed_opcode_o   = out_opc_q;
  assign instruction_count_o = out_count_q;

endmodule

// ===== hw/rtl/lc2k_instruction_executor_top.sv =====
// ----------------------------------------------------------------------------
// LC-2K instruction executor
// Loads program words, steps the eight-instruction LC-2K machine and reads
// back registers and memory words.
// ----------------------------------------------------------------------------
// Usage:
// Each input beat (in_valid_i while in_stall_o is low) carries one command:
// load a memory word, execute one instruction, read a register or read a
// memory word. Every command yields exactly one output beat with the machine
// status, the PC, the data read or written, the executed opcode and the
// instruction count.
// States from input beat to output valid: load S_LOAD, S_RESP; stopped step
// S_FETCH, S_RESP; register or memory read S_RDREG or S_RDMEM, then S_CAPREG
// or S_CAPMEM, S_RESP; unrecognized opcode S_FETCH, S_DECODE, S_RESP; other
// steps add S_EXEC before S_RESP, and lw also S_WB. The block takes one
// command at a time and is ready again once output valid rises; the
// single-port word memory, read in fetch and again for lw, sets these steps.
// Reset clears the PC, the registers, the count and the flags; memory words
// are undefined until loaded, and no clearing pass runs.
// A finished beat waits in the output register while out_stall_i is high;
// the next command is taken meanwhile and holds in its response state until
// the output register frees.
// ----------------------------------------------------------------------------
module lc2k_instruction_executor_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [1:0]                          command_i,
  input  logic [lc2k_pkg::ADDR_W-1:0]         address_i,
  input  logic [2:0]                          reg_index_i,
  input  logic signed [lc2k_pkg::WORD_W-1:0]  load_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [1:0]                          status_o,
  output logic [lc2k_pkg::ADDR_W-1:0]         pc_value_o,
  output logic signed [lc2k_pkg::WORD_W-1:0]  read_data_o,
  output logic [2:0]                          executed_opcode_o,
  output logic [lc2k_pkg::WORD_W-1:0]         instruction_count_o
);
  import lc2k_pkg::*;

  dp_ctl_t  ctl;
  dp_stat_t stat;

  lc2k_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .command_i   (command_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .ctl_o       (ctl)
  );

  lc2k_dp u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .address_i           (address_i),
    .reg_index_i         (reg_index_i),
    .load_data_i         (load_data_i),
    .ctl_i               (ctl),
    .stat_o              (stat),
    .status_o            (status_o),
    .pc_value_o          (pc_value_o),
    .read_data_o         (read_data_o),
    .executed_opcode_o   (executed_opcode_o),
    .instruction_count_o (instruction_count_o)
  );

endmodule

// ===== hw/rtl/lc2k_chk.sv =====
// ----------------------------------------------------------------------------
// LC-2K executor port checker
// Watches the top-level ports for handshake and result consistency.
// ----------------------------------------------------------------------------
module lc2k_chk (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_stall_o,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic [1:0]                          status_o,
  input logic [lc2k_pkg::ADDR_W-1:0]         pc_value_o,
  input logic signed [lc2k_pkg::WORD_W-1:0]  read_data_o,
  input logic [2:0]                          executed_opcode_o,
  input logic [lc2k_pkg::WORD_W-1:0]         instruction_count_o
);
  import lc2k_pkg::*;

  // A stalled output beat stays valid and unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(read_data_o) &&
      $stable(status_o) && $stable(pc_value_o) && $stable(instruction_count_o))
    else $error("stalled output beat changed");

  // Commands are taken one at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second command taken while one is in flight");

  // A machine stopped on a bad opcode never reports an executed instruction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_ERROR |-> executed_opcode_o == OP_ADD)
    else $error("opcode reported with error status");

  // An executed non-zero opcode implies a non-zero count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && executed_opcode_o != OP_ADD |-> instruction_count_o != '0)
    else $error("instruction executed but count is zero");

endmodule

bind lc2k_instruction_executor_top lc2k_chk u_chk (.*);
